>>> rtl/vkf_pkg.sv
// shared types, constants and helpers of the velocity kalman filter
`default_nettype none

package vkf_pkg;

    // axis layout
    localparam int NUM_AX  = 3;
    localparam int AX_W    = 2;
    localparam int DEF_AXES = 3;
    localparam logic [AX_W-1:0] AXIS_X = 2'd0;
    localparam logic [AX_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AX_W-1:0] AXIS_Z = 2'd2;

    // field widths
    localparam int VEL_W  = 32;
    localparam int VAR_W  = 48;
    localparam int DT_W   = 24;
    localparam int GAIN_W = 32;

    // gain of exactly one in q1.31 and the number of quotient bits
    localparam logic [GAIN_W-1:0] GAIN_ONE = 32'h8000_0000;
    localparam int DIV_STEPS = 31;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_VAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 2'd2;

    localparam logic [VAR_W-1:0]        RST_PROC_VAR = 48'd1099511627776;
    localparam logic [VAR_W-1:0]        RST_MEAS_VAR = 48'd10995;
    localparam logic signed [VEL_W-1:0] RST_GRAVITY  = 32'sd642908;

    typedef struct packed {
        logic signed [VEL_W-1:0] meas_vel_x;
        logic signed [VEL_W-1:0] meas_vel_y;
        logic signed [VEL_W-1:0] meas_vel_z;
        logic signed [VEL_W-1:0] accel_x;
        logic signed [VEL_W-1:0] accel_y;
        logic signed [VEL_W-1:0] accel_z;
        logic [DT_W-1:0]         step_dt;
    } t_vkf_in;

    typedef struct packed {
        logic signed [VEL_W-1:0] est_vel_x;
        logic signed [VEL_W-1:0] est_vel_y;
        logic signed [VEL_W-1:0] est_vel_z;
        logic                    passed_through;
    } t_vkf_out;

    // clamp a wide signed sum to the velocity range
    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [48:0] v);
        logic signed [48:0] v_max;
        logic signed [48:0] v_min;
        v_max = 49'sh0_0000_7FFF_FFFF;
        v_min = -49'sh0_0000_8000_0000;
        if (v > v_max) begin
            return 32'sh7FFF_FFFF;
        end else if (v < v_min) begin
            return -32'sh8000_0000;
        end else begin
            return v[VEL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/vkf_gain_div.sv
// iterative restoring divider for the kalman gain p/(p+r) in q1.31
`default_nettype none

module vkf_gain_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vkf_pkg::VAR_W-1:0]    i_var_p,
    input  logic [vkf_pkg::VAR_W-1:0]    i_var_r,
    output logic                         o_done,
    output logic [vkf_pkg::GAIN_W-1:0]   o_gain
);
    import vkf_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [VAR_W:0]     w_sum;
    logic [VAR_W+1:0]   w_shift;
    logic [VAR_W+1:0]   w_diff;
    logic               w_ge;

    logic [VAR_W:0]     r_den;
    logic [VAR_W:0]     r_rem;
    logic [GAIN_W-1:0]  r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    assign w_sum   = {1'b0, i_var_p} + {1'b0, i_var_r};
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= w_sum;
                r_rem <= {1'b0, i_var_p};
                r_cnt <= '0;
                priority if (w_sum == '0) begin
                    // no variance at all: keep the prediction
                    r_q    <= '0;
                    r_done <= 1'b1;
                end else if (i_var_r == '0) begin
                    // exact measurement: gain of one
                    r_q    <= GAIN_ONE;
                    r_done <= 1'b1;
                end else begin
                    r_q    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[VAR_W:0] : w_shift[VAR_W:0];
                r_q   <= {r_q[GAIN_W-2:0], w_ge};
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_q;

endmodule

`default_nettype wire

>>> rtl/velocity_kalman_filter.sv
// top level of the three axis velocity kalman filter
`default_nettype none

// Three independent scalar Kalman filters, one per velocity axis, share one
// multiplier and one bit-per-cycle divider under a small sequencer. A
// transaction brings measured velocity, average acceleration and dt; each
// active axis is predicted (x += dt*(a-g), gravity on z only), its variance
// grown by Q, the gain P/(P+R) divided out one quotient bit per cycle,
// and the estimate corrected and the variance shrunk. The 31 step gain
// divider on each axis sets how long an item takes; an axis whose gain is
// trivially zero or one skips the divider steps. The first item after reset
// passes the measurement through. Input ready is high only while the
// sequencer is idle. The result sits in an output register, so the next
// item can be taken while it waits. The user must write the configuration
// registers through the plain write port only while the block is idle; the
// block itself does not enforce this.

module velocity_kalman_filter #(
    parameter int AXES = vkf_pkg::DEF_AXES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [vkf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vkf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  vkf_pkg::t_vkf_in                i_in_data,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output vkf_pkg::t_vkf_out               o_out_data
);
    import vkf_pkg::*;

    localparam logic [AX_W-1:0] LAST_AX = AX_W'(AXES - 1);

    // one-hot sequencer states
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_PRED_MUL = 10'b00_0000_0010,
        S_PRED_ADD = 10'b00_0000_0100,
        S_DIV      = 10'b00_0000_1000,
        S_CORR_MUL = 10'b00_0001_0000,
        S_CORR_ADD = 10'b00_0010_0000,
        S_SHR_HI   = 10'b00_0100_0000,
        S_SHR_LO   = 10'b00_1000_0000,
        S_SHR_ADD  = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    t_state                  r_state;

    // configuration registers
    logic [VAR_W-1:0]        r_proc_var;
    logic [VAR_W-1:0]        r_meas_var;
    logic signed [VEL_W-1:0] r_gravity;

    // filter state per axis
    logic signed [VEL_W-1:0] r_est [NUM_AX];
    logic [VAR_W-1:0]        r_cov [NUM_AX];
    logic                    r_started;

    // transaction in flight and results
    t_vkf_in                 r_in;
    t_vkf_out                r_res;
    t_vkf_out                r_out;
    logic                    r_out_valid;

    // working registers of the current axis
    logic [AX_W-1:0]         r_axis;
    logic signed [VEL_W-1:0] r_x;
    logic [VAR_W-1:0]        r_p;
    logic [GAIN_W-1:0]       r_k;
    logic                    r_neg;
    logic [63:0]             r_prod;
    logic [55:0]             r_hold;

    // per axis views of the latched transaction
    logic signed [VEL_W-1:0] w_meas  [NUM_AX];
    logic signed [VEL_W-1:0] w_accel [NUM_AX];

    logic                    w_in_acc;
    logic                    w_out_free;
    t_vkf_out                w_pass_res;
    logic signed [32:0]      w_accel_eff;
    logic [VAR_W:0]          w_p_sum;
    logic [VAR_W-1:0]        w_p_grow;
    logic signed [32:0]      w_err;
    logic [32:0]             w_mag;
    logic [GAIN_W-1:0]       w_m;
    logic signed [33:0]      w_op_a;
    logic signed [33:0]      w_op_b;
    logic signed [67:0]      w_prod;
    logic signed [63:0]      w_d_full;
    logic signed [48:0]      w_x_pred_sum;
    logic [63:0]             w_rnd;
    logic [32:0]             w_corr;
    logic signed [48:0]      w_x_corr_sum;
    logic signed [VEL_W-1:0] w_x_pred;
    logic signed [VEL_W-1:0] w_x_corr;
    logic [56:0]             w_shr_lo;
    logic [48:0]             w_shr_sum;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [GAIN_W-1:0]       w_div_q;

    assign w_meas[0]  = r_in.meas_vel_x;
    assign w_meas[1]  = r_in.meas_vel_y;
    assign w_meas[2]  = r_in.meas_vel_z;
    assign w_accel[0] = r_in.accel_x;
    assign w_accel[1] = r_in.accel_y;
    assign w_accel[2] = r_in.accel_z;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // pass-through result of the first transaction, unused axes stay zero
    always_comb begin
        w_pass_res                = '0;
        w_pass_res.passed_through = 1'b1;
        w_pass_res.est_vel_x      = i_in_data.meas_vel_x;
        if (AXES > 1) begin
            w_pass_res.est_vel_y = i_in_data.meas_vel_y;
        end
        if (AXES > 2) begin
            w_pass_res.est_vel_z = i_in_data.meas_vel_z;
        end
    end

    // prediction: control input, gravity taken off z only
    assign w_accel_eff = {w_accel[r_axis][VEL_W-1], w_accel[r_axis]}
                       - ((r_axis == AXIS_Z) ? {r_gravity[VEL_W-1], r_gravity} : 33'sd0);

    // variance growth, saturating at full scale
    assign w_p_sum  = {1'b0, r_cov[r_axis]} + {1'b0, r_proc_var};
    assign w_p_grow = w_p_sum[VAR_W] ? {VAR_W{1'b1}} : w_p_sum[VAR_W-1:0];

    // innovation magnitude and sign
    assign w_err = {w_meas[r_axis][VEL_W-1], w_meas[r_axis]} - {r_x[VEL_W-1], r_x};
    assign w_mag = w_err[32] ? (33'd0 - w_err) : w_err;

    // one minus gain for the variance shrink
    assign w_m = GAIN_ONE - r_k;

    // shared multiplier, operands picked by the sequencer
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_state)
            S_PRED_MUL: begin
                w_op_a = {w_accel_eff[32], w_accel_eff};
                w_op_b = {10'b0, r_in.step_dt};
            end
            S_CORR_MUL: begin
                w_op_a = {1'b0, w_mag};
                w_op_b = {2'b0, r_k};
            end
            S_SHR_HI: begin
                w_op_a = {2'b0, w_m};
                w_op_b = {10'b0, r_p[47:24]};
            end
            S_SHR_LO: begin
                w_op_a = {2'b0, w_m};
                w_op_b = {10'b0, r_p[23:0]};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // velocity step rounded to q.16, then added with saturation
    assign w_d_full     = ($signed(r_prod) + 64'sd32768) >>> 16;
    assign w_x_pred_sum = {{17{r_est[r_axis][VEL_W-1]}}, r_est[r_axis]} + w_d_full[48:0];
    assign w_x_pred     = sat_vel(w_x_pred_sum);

    // correction rounded half away from zero
    assign w_rnd        = r_prod + 64'd1073741824;
    assign w_corr       = w_rnd[63:31];
    assign w_x_corr_sum = r_neg ? ({{17{r_x[VEL_W-1]}}, r_x} - {16'b0, w_corr})
                                : ({{17{r_x[VEL_W-1]}}, r_x} + {16'b0, w_corr});
    assign w_x_corr     = sat_vel(w_x_corr_sum);

    // variance shrink: high partial product in r_hold, low one in r_prod
    assign w_shr_lo  = {26'b0, r_hold[6:0], 24'b0} + {1'b0, r_prod[55:0]};
    assign w_shr_sum = r_hold[55:7] + {23'b0, w_shr_lo[56:31]};

    assign w_div_start = (r_state == S_PRED_ADD);

    vkf_gain_div u_gain_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_var_p (r_p),
        .i_var_r (r_meas_var),
        .o_done  (w_div_done),
        .o_gain  (w_div_q)
    );

    // configuration registers, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_var <= RST_PROC_VAR;
            r_meas_var <= RST_MEAS_VAR;
            r_gravity  <= RST_GRAVITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROC_VAR: r_proc_var <= i_cfg_wdata[VAR_W-1:0];
                CFG_MEAS_VAR: r_meas_var <= i_cfg_wdata[VAR_W-1:0];
                CFG_GRAVITY:  r_gravity  <= i_cfg_wdata[VEL_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            for (int i = 0; i < NUM_AX; i++) begin
                r_est[i] <= '0;
                r_cov[i] <= RST_PROC_VAR;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_in   <= i_in_data;
                        r_axis <= '0;
                        if (r_started) begin
                            r_res   <= '0;
                            r_state <= S_PRED_MUL;
                        end else begin
                            // first transaction: pass through, load covariance
                            r_res <= w_pass_res;
                            for (int i = 0; i < AXES; i++) begin
                                r_cov[i] <= r_proc_var;
                            end
                            r_started <= 1'b1;
                            r_state   <= S_OUT;
                        end
                    end
                end
                S_PRED_MUL: begin
                    r_prod  <= w_prod[63:0];
                    r_p     <= w_p_grow;
                    r_state <= S_PRED_ADD;
                end
                S_PRED_ADD: begin
                    // divider starts on this cycle with the grown variance
                    r_x     <= w_x_pred;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_k     <= w_div_q;
                        r_state <= S_CORR_MUL;
                    end
                end
                S_CORR_MUL: begin
                    r_prod  <= w_prod[63:0];
                    r_neg   <= w_err[32];
                    r_state <= S_CORR_ADD;
                end
                S_CORR_ADD: begin
                    r_x           <= w_x_corr;
                    r_est[r_axis] <= w_x_corr;
                    unique case (r_axis)
                        AXIS_X:  r_res.est_vel_x <= w_x_corr;
                        AXIS_Y:  r_res.est_vel_y <= w_x_corr;
                        AXIS_Z:  r_res.est_vel_z <= w_x_corr;
                        default: ;
                    endcase
                    r_state <= S_SHR_HI;
                end
                S_SHR_HI: begin
                    r_prod  <= w_prod[63:0];
                    r_state <= S_SHR_LO;
                end
                S_SHR_LO: begin
                    r_hold  <= r_prod[55:0];
                    r_prod  <= w_prod[63:0];
                    r_state <= S_SHR_ADD;
                end
                S_SHR_ADD: begin
                    r_cov[r_axis] <= w_shr_sum[VAR_W-1:0];
                    if (r_axis == LAST_AX) begin
                        r_state <= S_OUT;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_PRED_MUL;
                    end
                end
                S_OUT: begin
                    // hand over once the output register is free
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register: loaded from the sequencer, held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == S_OUT) && w_out_free)
                        || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> verif/velocity_kalman_filter_tb.sv
// self-checking testbench of the velocity kalman filter, directed and random transactions
`timescale 1ns / 100ps

module velocity_kalman_filter_tb;
    import vkf_pkg::*;

    // run shape
    localparam int VEL_MAX        = 32'sh7FFF_FFFF;
    localparam int VEL_MIN        = 32'sh8000_0000;
    localparam int unsigned DT_MAX  = 24'hFF_FFFF;
    localparam int unsigned ONE_SEC = 65536;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int BLOCK_ITEMS    = 200;
    localparam int DRAIN_CYCLES   = 300;
    localparam int LONG_HOLD      = 3000;
    localparam int HOLD_AT_FIRST  = 400;
    localparam int HOLD_AT_SECOND = 1500;

    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // how often each side idles
    typedef enum int {
        PACE_RX_SLOW,   // sender idles 35 of 100, receiver 72
        PACE_TX_SLOW,   // sender idles 72 of 100, receiver 35
        PACE_FULL       // nobody idles
    } t_pace;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_vkf_in               i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_vkf_out              o_out_data;

    velocity_kalman_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // filter state as the predictor sees it, plus its copy of the registers
    longint                  vel_est [NUM_AX] = '{default: 0};
    logic [VAR_W-1:0]        var_est [NUM_AX] = '{default: RST_PROC_VAR};
    bit                      filter_started = 1'b0;
    logic [VAR_W-1:0]        cfg_q = RST_PROC_VAR;
    logic [VAR_W-1:0]        cfg_r = RST_MEAS_VAR;
    logic signed [VEL_W-1:0] cfg_g = RST_GRAVITY;

    // items waiting to be offered and estimates waiting to come out
    t_vkf_in  sample_queue [$];
    t_vkf_out pending_estimates [$];
    t_vkf_out want;

    t_pace pace = PACE_RX_SLOW;
    bit    in_flight = 1'b0;
    bit    hold_request = 1'b0;
    int    hold_cycles = 0;
    int    items_taken = 0;
    int    results_seen = 0;
    int    settings_used = 0;
    int    mismatches = 0;
    int    cycle_count = 0;

    function automatic longint clamp_vel(input longint v);
        if (v > longint'(VEL_MAX)) return VEL_MAX;
        if (v < longint'(VEL_MIN)) return VEL_MIN;
        return v;
    endfunction

    // one filter update per transaction, fixed point at the block's widths
    function automatic t_vkf_out estimate_velocity(input t_vkf_in smp);
        t_vkf_out                res;
        logic signed [VEL_W-1:0] meas [NUM_AX];
        logic signed [VEL_W-1:0] acc [NUM_AX];
        logic signed [VEL_W-1:0] outv [NUM_AX];
        longint                  drive;
        longint                  x;
        longint                  err;
        longint                  corr;
        logic [VAR_W:0]          grown;
        logic [VAR_W:0]          total;
        logic [VAR_W-1:0]        p;
        logic [GAIN_W-1:0]       k;
        logic [GAIN_W-1:0]       keep;
        logic [63:0]             mag;
        logic [95:0]             wide;
        int                      ax;
        meas[0] = smp.meas_vel_x;
        meas[1] = smp.meas_vel_y;
        meas[2] = smp.meas_vel_z;
        acc[0]  = smp.accel_x;
        acc[1]  = smp.accel_y;
        acc[2]  = smp.accel_z;
        for (ax = 0; ax < NUM_AX; ax++) begin
            if (!filter_started) begin
                // first transaction: measurement goes straight out, P reloaded from Q
                var_est[ax] = cfg_q;
                outv[ax] = meas[ax];
            end else begin
                // predict with the acceleration, rounded to q.16
                drive = longint'(acc[ax]);
                if (ax == AXIS_Z) drive -= longint'(cfg_g);
                drive = (drive * longint'(smp.step_dt) + 32768) >>> 16;
                x = clamp_vel(vel_est[ax] + drive);
                // grow the variance, saturating at full scale
                grown = {1'b0, var_est[ax]} + {1'b0, cfg_q};
                p = grown[VAR_W] ? '1 : grown[VAR_W-1:0];
                // gain in q1.31, zero when there is no variance at all
                total = {1'b0, p} + {1'b0, cfg_r};
                if (total == '0) begin
                    k = '0;
                end else begin
                    wide = 96'(p) << 31;
                    wide = wide / 96'(total);
                    k = wide[GAIN_W-1:0];
                end
                // correct, rounding the magnitude half away from zero
                err = longint'(meas[ax]) - x;
                mag = (err < 0) ? -err : err;
                wide = 96'(mag) * 96'(k) + (96'd1 << 30);
                corr = longint'(wide >> 31);
                x = clamp_vel((err < 0) ? x - corr : x + corr);
                vel_est[ax] = x;
                // shrink the variance by (1 - k), floor
                keep = GAIN_ONE - k;
                wide = 96'(p) * 96'(keep);
                var_est[ax] = wide[VAR_W+30:31];
                outv[ax] = x[VEL_W-1:0];
            end
        end
        res.est_vel_x = outv[0];
        res.est_vel_y = outv[1];
        res.est_vel_z = outv[2];
        res.passed_through = !filter_started;
        filter_started = 1'b1;
        return res;
    endfunction

    function automatic t_vkf_in make_sample(input int mx, input int my, input int mz,
                                            input int ax, input int ay, input int az,
                                            input int unsigned dt);
        t_vkf_in smp;
        smp.meas_vel_x = mx;
        smp.meas_vel_y = my;
        smp.meas_vel_z = mz;
        smp.accel_x    = ax;
        smp.accel_y    = ay;
        smp.accel_z    = az;
        smp.step_dt    = dt[DT_W-1:0];
        return smp;
    endfunction

    // append an item to the end of the send queue
    task automatic queue_sample(input t_vkf_in smp);
        sample_queue.insert(sample_queue.size(), smp);
    endtask

    // mostly plausible values around zero, sometimes the full range or an extreme
    function automatic int rand_vel(input int span);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VEL_MAX;
                    1: return VEL_MIN;
                    2: return 0;
                    default: return -1;
                endcase
            end
            1, 2: return $urandom();
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    // variances spread over many magnitudes, zero and full scale included
    function automatic logic [VAR_W-1:0] pick_variance();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return raw[VAR_W-1:0];
            3: return RST_PROC_VAR;
            4: return RST_MEAS_VAR;
            default: return raw[VAR_W-1:0] >> $urandom_range(4, 47);
        endcase
    endfunction

    // register write, only while nothing is in flight
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_PROC_VAR: cfg_q = data[VAR_W-1:0];
            CFG_MEAS_VAR: cfg_r = data[VAR_W-1:0];
            CFG_GRAVITY:  cfg_g = data[VEL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_settings();
        logic [VEL_W-1:0] grav;
        write_register(CFG_PROC_VAR, pick_variance());
        write_register(CFG_MEAS_VAR, pick_variance());
        case ($urandom_range(0, 5))
            0: grav = RST_GRAVITY;
            1: grav = VEL_MIN;
            2: grav = VEL_MAX;
            3: grav = '0;
            default: grav = $urandom();
        endcase
        // upper bits of the write data are junk for the gravity register
        write_register(CFG_GRAVITY, {16'($urandom()), grav});
        if ($urandom_range(0, 2) == 0) write_register(CFG_SPARE, {16'($urandom()), $urandom()});
        settings_used++;
    endtask

    task automatic wait_for_quiet();
        while (sample_queue.size() != 0 || in_flight || pending_estimates.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input longint exp_val, input longint got);
        if (exp_val != got) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got);
            mismatches++;
        end
    endtask

    // input side: predict on every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_estimates.insert(pending_estimates.size(), estimate_velocity(i_in_data));
            items_taken++;
            in_flight = 1'b0;
        end
    end

    // input side: offer the next item, holding it until it is taken
    always @(negedge i_clk) begin
        if (!in_flight) begin
            if (sample_queue.size() != 0 &&
                !(pace == PACE_RX_SLOW && $urandom_range(0, 99) < 35) &&
                !(pace == PACE_TX_SLOW && $urandom_range(0, 99) < 72)) begin
                i_in_data  <= sample_queue.pop_front();
                i_in_valid <= 1'b1;
                in_flight = 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side: compare every accepted result with the oldest estimate
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_estimates.size() == 0) begin
                $error("result transaction arrived with no estimate pending");
                mismatches++;
            end else begin
                want = pending_estimates.pop_front();
                check_field("est_vel_x", want.est_vel_x, o_out_data.est_vel_x);
                check_field("est_vel_y", want.est_vel_y, o_out_data.est_vel_y);
                check_field("est_vel_z", want.est_vel_z, o_out_data.est_vel_z);
                check_field("passed_through", want.passed_through, o_out_data.passed_through);
            end
            results_seen++;
            if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
                hold_request = 1'b1;
        end
    end

    // output side: random back-pressure, plus long hold-offs so the input stalls
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            case (pace)
                PACE_RX_SLOW: i_out_ready <= ($urandom_range(0, 99) >= 72);
                PACE_TX_SLOW: i_out_ready <= ($urandom_range(0, 99) >= 35);
                default:      i_out_ready <= 1'b1;
            endcase
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d estimates still pending",
                 cycle_count, pending_estimates.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        int          ph;
        int          blk;
        int          i;
        int unsigned dt;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: pass-through first, then saturation and rounding corners
        queue_sample(make_sample(VEL_MAX, VEL_MIN, -1,
                                 $urandom(), $urandom(), $urandom(), DT_MAX));
        queue_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
        queue_sample(make_sample(6553600, -6553600, 655360,
                                 65536, -65536, 642908 + 65536, 655));
        queue_sample(make_sample(VEL_MAX, VEL_MAX, VEL_MAX,
                                 VEL_MAX, VEL_MAX, VEL_MAX, DT_MAX));
        queue_sample(make_sample(VEL_MIN, VEL_MIN, VEL_MIN,
                                 VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX));
        queue_sample(make_sample(-1, 1, 0, -65536, 65536, 642908, ONE_SEC));
        queue_sample(make_sample(VEL_MAX, VEL_MIN, 1, 0, 0, 0, 1));
        wait_for_quiet();

        // no variance anywhere: unit gain once, then the prediction alone survives
        write_register(CFG_PROC_VAR, '0);
        write_register(CFG_MEAS_VAR, '0);
        write_register(CFG_GRAVITY, 48'hABCD_8000_0000);
        write_register(CFG_SPARE, '1);
        settings_used++;
        queue_sample(make_sample(3276800, -3276800, 100, 0, 0, 0, 0));
        queue_sample(make_sample(0, 0, 0, 65536, -65536, VEL_MAX, DT_MAX));
        queue_sample(make_sample(VEL_MIN, VEL_MAX, 0,
                                 VEL_MIN, VEL_MAX, VEL_MIN, DT_MAX));
        queue_sample(make_sample(123, -123, 0, 1, -1, 0, 1));
        wait_for_quiet();

        // full-scale variances, covariance growth saturates
        write_register(CFG_PROC_VAR, '1);
        write_register(CFG_MEAS_VAR, '1);
        write_register(CFG_GRAVITY, {16'h0000, 32'h7FFF_FFFF});
        settings_used++;
        queue_sample(make_sample(VEL_MAX, VEL_MIN, VEL_MAX, 0, 0, 0, 0));
        queue_sample(make_sample(VEL_MIN, VEL_MAX, VEL_MIN,
                                 VEL_MAX, VEL_MIN, VEL_MIN, DT_MAX));
        queue_sample(make_sample(-3, 3, -1, -1, 1, VEL_MAX, 3));
        queue_sample(make_sample(0, 0, 0, 0, 0, 0, DT_MAX));
        wait_for_quiet();

        // no process noise, large R: gain decays item by item
        write_register(CFG_PROC_VAR, '0);
        write_register(CFG_MEAS_VAR, RST_PROC_VAR);
        write_register(CFG_GRAVITY, '0);
        settings_used++;
        for (i = 0; i < 4; i++)
            queue_sample(make_sample(6553600 + i, -655360 - i, 196608 * i,
                                     32768, -32768, i, 6554));

        // random part: three pacing phases, three register settings in each
        for (ph = 0; ph < 3; ph++) begin
            for (blk = 0; blk < 3; blk++) begin
                // settings only change once every estimate has come out
                wait_for_quiet();
                pace = t_pace'(ph);
                pick_settings();
                repeat (BLOCK_ITEMS) begin
                    case ($urandom_range(0, 9))
                        0:       dt = $urandom_range(0, 1) ? DT_MAX : 0;
                        1, 2:    dt = $urandom_range(0, DT_MAX);
                        default: dt = $urandom_range(0, 6553);
                    endcase
                    queue_sample(make_sample(
                        rand_vel(3276800), rand_vel(3276800), rand_vel(3276800),
                        rand_vel(1310720), rand_vel(1310720), rand_vel(1310720), dt));
                end
            end
        end

        wait_for_quiet();
        // anything that shows up now has no estimate and gets flagged
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("checked %0d results from %0d transactions over %0d register settings",
                 results_seen, items_taken, settings_used);
        $display("covered pass-through, saturation, zero and unit gain, two long output stalls");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> velocity_kalman_filter.f
rtl/vkf_pkg.sv
rtl/vkf_gain_div.sv
rtl/velocity_kalman_filter.sv
verif/velocity_kalman_filter_tb.sv
